>>> rtl/facl_pkg.sv
`timescale 1ns / 1ps

package facl_pkg;

  localparam int TIME_WIDTH_DEF = 32;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int TARGET_W   = 12;
  localparam int ACK_W      = 32;
  localparam int LEVER_W    = 10;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_LINK_TIMEOUT  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SEND_INTERVAL = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_NEUTRAL       = 2'd2;

  localparam logic [15:0]         LINK_TIMEOUT_RST  = 16'd500;
  localparam logic [15:0]         SEND_INTERVAL_RST = 16'd100;
  localparam logic [TARGET_W-1:0] NEUTRAL_RST       = 12'd2048;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_PACKET = 1'b1;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_ACK   = 1'b1;

  localparam logic [7:0] FRAME_SYNC = 8'hC0;
  localparam logic [7:0] MODE_TABLE = 8'd1;
  localparam logic [7:0] STOP_ON    = 8'd1;

  // One pending group of results: up to three bytes sent lowest first.
  typedef struct packed {
    logic [1:0]       cnt;
    logic             kind;
    logic [23:0]      bytes;
    logic [ACK_W-1:0] ack;
    logic             link;
  } grp_t;

  // The quotient floor((v + 100) / 102), saturated at 9, is the number of
  // thresholds 102*k - 100 (k = 1..9) that the lever value reaches.
  function automatic logic [TARGET_W-1:0] lever_target(input logic [LEVER_W-1:0] lever);
    logic [3:0] q;
    logic [TARGET_W-1:0] tgt;
    q = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if ({1'b0, lever} >= 11'(102 * k - 100)) begin
        q = q + 4'd1;
      end
    end
    unique case (q)
      4'd0:    tgt = 12'd1;
      4'd1:    tgt = 12'd819;
      4'd2:    tgt = 12'd1229;
      4'd3:    tgt = 12'd1638;
      4'd4:    tgt = 12'd2048;
      4'd5:    tgt = 12'd2458;
      4'd6:    tgt = 12'd2868;
      4'd7:    tgt = 12'd3277;
      4'd8:    tgt = 12'd3686;
      default: tgt = 12'd4095;
    endcase
    return tgt;
  endfunction

endpackage

>>> rtl/failsafe_actuator_command_link.sv
`timescale 1ns / 1ps

// Fail-safe actuator command link.
// Input channel (in_*): one item is either a millisecond tick (in_tuser = 0)
// or a received control packet (in_tuser = 1). A packet yields one
// acknowledgement result; a tick yields either nothing or a three-byte
// actuator frame (sync byte, low five target bits, upper seven target bits).
// Result channel (out_*): out_tuser gives the kind (0 frame byte, 1 ack),
// out_tlast marks the final result of one input item.
// An accepted item's results are held in the pending group register and
// then move into the single result register; frame bytes leave through it
// one per cycle while the receiver does not stall.
// A receiver stall holds the result register and, once the pending bytes of
// an item are queued, the input side; an item is still taken while the last
// result of the previous one waits in the output register.
// Reset (rst_n low, synchronous) restores the configuration defaults,
// clears time, link and ack state and drops any pending results.
// Configuration writes (cfg_we) are to be made only while idle; the block does not enforce it.
module failsafe_actuator_command_link
  import facl_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,   // lever_value, mode_byte, stop_byte, zero pad
  input  logic                  in_tuser,   // op
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata,  // frame_byte, ack_count, link_good, zero pad
  output logic                  out_tuser,  // kind
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [15:0]           link_timeout_r;
  logic [15:0]           send_interval_r;
  logic [TARGET_W-1:0]   neutral_r;

  logic [TIME_WIDTH-1:0] now_r, now_nxt;
  logic [TIME_WIDTH-1:0] last_rx_r, last_rx_nxt;
  logic [TIME_WIDTH-1:0] last_send_r, last_send_nxt;
  logic [TARGET_W-1:0]   held_r, held_nxt;
  logic                  stop_r, stop_nxt;
  logic                  link_r, link_nxt;
  logic [ACK_W-1:0]      acks_r, acks_nxt;

  grp_t                  grp_r, grp_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_kind_r, out_kind_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [7:0]            out_byte_r, out_byte_nxt;
  logic [ACK_W-1:0]      out_ack_r, out_ack_nxt;
  logic                  out_link_r, out_link_nxt;

  logic                  accept;
  logic                  move;
  logic [TIME_WIDTH-1:0] now_inc;
  logic                  tick_link;
  logic                  send_due;
  logic [TARGET_W-1:0]   frame_target;

  logic [LEVER_W-1:0]    in_lever;
  logic [7:0]            in_mode;
  logic [7:0]            in_stop;

  assign in_lever = in_tdata[9:0];
  assign in_mode  = in_tdata[17:10];
  assign in_stop  = in_tdata[25:18];

  // A new item may enter while the last pending result leaves.
  assign in_tready = (grp_r.cnt == 2'd0) || ((grp_r.cnt == 2'd1) && move);
  assign accept    = in_tvalid && in_tready;
  assign move      = (grp_r.cnt != 2'd0) && (!out_valid_r || out_tready);

  assign now_inc      = now_r + TIME_WIDTH'(1);
  assign tick_link    = (now_inc - last_rx_r) < TIME_WIDTH'(link_timeout_r);
  assign send_due     = (now_inc - last_send_r) >= TIME_WIDTH'(send_interval_r);
  assign frame_target = (!tick_link || stop_r) ? neutral_r : held_r;

  always_comb begin
    now_nxt       = now_r;
    last_rx_nxt   = last_rx_r;
    last_send_nxt = last_send_r;
    held_nxt      = held_r;
    stop_nxt      = stop_r;
    link_nxt      = link_r;
    acks_nxt      = acks_r;
    grp_nxt       = grp_r;

    if (move) begin
      grp_nxt.cnt   = grp_r.cnt - 2'd1;
      grp_nxt.bytes = {8'd0, grp_r.bytes[23:8]};
    end

    if (accept) begin
      if (in_tuser == OP_PACKET) begin
        held_nxt      = (in_mode == MODE_TABLE) ? lever_target(in_lever) : neutral_r;
        stop_nxt      = (in_stop == STOP_ON);
        acks_nxt      = acks_r + ACK_W'(1);
        last_rx_nxt   = now_r;
        grp_nxt.cnt   = 2'd1;
        grp_nxt.kind  = KIND_ACK;
        grp_nxt.bytes = 24'd0;
        grp_nxt.ack   = acks_r + ACK_W'(1);
        grp_nxt.link  = link_r;
      end else begin
        now_nxt  = now_inc;
        link_nxt = tick_link;
        if (send_due) begin
          last_send_nxt = now_inc;
          grp_nxt.cnt   = 2'd3;
          grp_nxt.kind  = KIND_FRAME;
          grp_nxt.bytes = {1'b0, frame_target[11:5], 3'd0, frame_target[4:0], FRAME_SYNC};
          grp_nxt.ack   = acks_r;
          grp_nxt.link  = tick_link;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    out_byte_nxt  = out_byte_r;
    out_ack_nxt   = out_ack_r;
    out_link_nxt  = out_link_r;
    if (move) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = grp_r.kind;
      out_last_nxt  = (grp_r.cnt == 2'd1);
      out_byte_nxt  = grp_r.bytes[7:0];
      out_ack_nxt   = grp_r.ack;
      out_link_nxt  = grp_r.link;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_timeout_r  <= LINK_TIMEOUT_RST;
      send_interval_r <= SEND_INTERVAL_RST;
      neutral_r       <= NEUTRAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LINK_TIMEOUT:  link_timeout_r  <= cfg_wdata;
        REG_SEND_INTERVAL: send_interval_r <= cfg_wdata;
        REG_NEUTRAL:       neutral_r       <= cfg_wdata[TARGET_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r       <= '0;
      last_rx_r   <= '0;
      last_send_r <= '0;
      held_r      <= NEUTRAL_RST;
      stop_r      <= 1'b0;
      link_r      <= 1'b0;
      acks_r      <= '0;
      grp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      now_r       <= now_nxt;
      last_rx_r   <= last_rx_nxt;
      last_send_r <= last_send_nxt;
      held_r      <= held_nxt;
      stop_r      <= stop_nxt;
      link_r      <= link_nxt;
      acks_r      <= acks_nxt;
      grp_r       <= grp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r  <= out_kind_nxt;
    out_last_r  <= out_last_nxt;
    out_byte_r  <= out_byte_nxt;
    out_ack_r   <= out_ack_nxt;
    out_link_r  <= out_link_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'd0, out_link_r, out_ack_r, out_byte_r};

endmodule

>>> rtl/facl_checker.sv
`timescale 1ns / 1ps

module facl_checker
  import facl_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // Acknowledgements stand alone and carry no frame byte.
  a_ack_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ACK |-> out_tlast && out_tdata[7:0] == 8'd0)
    else $error("malformed acknowledgement");

  // The sync byte never ends a frame; data bytes never reach the sync pattern.
  a_sync_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_FRAME && out_tdata[7:0] == FRAME_SYNC |-> !out_tlast)
    else $error("frame ends on sync byte");

  // The middle byte of a frame holds only five target bits.
  a_low_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_FRAME && !out_tlast && out_tdata[7:0] != FRAME_SYNC
    |-> out_tdata[7:5] == 3'd0)
    else $error("low target byte out of range");

  // Reset drops any pending result.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind failsafe_actuator_command_link facl_checker u_facl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import facl_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 80;
  localparam int PHASE_ITEMS  = 24;
  localparam int NUM_PHASES   = 5;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic             kind;
    logic [7:0]       fbyte;
    logic             last;
    logic [ACK_W-1:0] acks;
    logic             link;
  } link_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [31:0]           in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [47:0]           out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Shadow copy of the link state and its registers.
  logic [15:0]          link_timeout;
  logic [15:0]          send_interval;
  logic [TARGET_W-1:0]  neutral_tgt;
  logic [TARGET_W-1:0]  held_tgt;
  logic [31:0]          now_ms;
  logic [31:0]          last_rx_ms;
  logic [31:0]          last_send_ms;
  logic                 stop_on;
  logic                 link_up;
  logic [ACK_W-1:0]     acks_sent;

  link_result_t pending_results_q[$];
  int  mismatch_count = 0;
  int  cycle_count = 0;
  bit  idle_on;
  bit  hold_req;

  failsafe_actuator_command_link i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** failsafe_actuator_command_link: FAILED **");
      $finish;
    end
  end

  function automatic void push_result(input logic kind, input logic [7:0] fbyte,
                                      input logic last);
    link_result_t r;
    r.kind  = kind;
    r.fbyte = fbyte;
    r.last  = last;
    r.acks  = acks_sent;
    r.link  = link_up;
    pending_results_q.push_back(r);
  endfunction

  function automatic void predict_link_step(input logic op, input logic [LEVER_W-1:0] lever,
                                            input logic [7:0] mode, input logic [7:0] stop);
    int                  q;
    logic [TARGET_W-1:0] tgt;
    logic [31:0]         since_rx;
    logic [31:0]         since_send;
    if (op == OP_PACKET) begin
      // The lever range is cut into ten buckets; high readings saturate.
      q = (int'(lever) + 100) / 102;
      case (q)
        0:       tgt = 12'd1;
        1:       tgt = 12'd819;
        2:       tgt = 12'd1229;
        3:       tgt = 12'd1638;
        4:       tgt = 12'd2048;
        5:       tgt = 12'd2458;
        6:       tgt = 12'd2868;
        7:       tgt = 12'd3277;
        8:       tgt = 12'd3686;
        default: tgt = 12'd4095;
      endcase
      held_tgt   = (mode == MODE_TABLE) ? tgt : neutral_tgt;
      stop_on    = (stop == STOP_ON);
      acks_sent  = acks_sent + 1'b1;
      last_rx_ms = now_ms;
      push_result(KIND_ACK, 8'h00, 1'b1);
    end else begin
      now_ms     = now_ms + 1'b1;
      since_rx   = now_ms - last_rx_ms;
      since_send = now_ms - last_send_ms;
      link_up    = since_rx < {16'd0, link_timeout};
      if (since_send >= {16'd0, send_interval}) begin
        tgt = (!link_up || stop_on) ? neutral_tgt : held_tgt;
        push_result(KIND_FRAME, FRAME_SYNC, 1'b0);
        push_result(KIND_FRAME, {3'd0, tgt[4:0]}, 1'b0);
        push_result(KIND_FRAME, {1'b0, tgt[11:5]}, 1'b1);
        last_send_ms = now_ms;
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= 50) begin
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  always @(posedge clk) begin : check_results
    link_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results_q.size() == 0) begin
        report_mismatch("unexpected result", out_tdata, 0);
      end else begin
        want = pending_results_q.pop_front();
        if (out_tuser !== want.kind) report_mismatch("kind", out_tuser, want.kind);
        if (out_tdata[7:0] !== want.fbyte) report_mismatch("frame_byte", out_tdata[7:0], want.fbyte);
        if (out_tlast !== want.last) report_mismatch("last", out_tlast, want.last);
        if (out_tdata[39:8] !== want.acks) report_mismatch("ack_count", out_tdata[39:8], want.acks);
        if (out_tdata[40] !== want.link) report_mismatch("link_good", out_tdata[40], want.link);
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_tready <= !idle_on || ($urandom_range(99) >= 17);
    end
  end

  task automatic send_item(input logic op, input logic [LEVER_W-1:0] lever,
                           input logic [7:0] mode, input logic [7:0] stop);
    while (idle_on && $urandom_range(99) < 17) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'd0, stop, mode, lever};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_link_step(op, lever, mode, stop);
    @(negedge clk);
  endtask

  task automatic send_random_item;
    logic                op;
    logic [LEVER_W-1:0]  lever;
    logic [7:0]          mode;
    logic [7:0]          stop;
    op = ($urandom_range(99) < 35) ? OP_PACKET : OP_TICK;
    if ($urandom_range(9) == 0) begin
      lever = $urandom_range(1) ? 10'd1023 : 10'd0;
    end else begin
      lever = 10'($urandom_range(1023));
    end
    mode = $urandom_range(1) ? MODE_TABLE : 8'($urandom_range(255));
    stop = ($urandom_range(99) < 30) ? STOP_ON : 8'($urandom_range(255));
    send_item(op, lever, mode, stop);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LINK_TIMEOUT:  link_timeout  = val;
      REG_SEND_INTERVAL: send_interval = val;
      REG_NEUTRAL:       neutral_tgt   = val[TARGET_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // A tick without a frame gives no result, so wait DRAIN_CYCLES past the
  // last result before the block is taken as idle.
  task automatic settle;
    in_tvalid <= 1'b0;
    while (pending_results_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic test_reset_defaults;
    send_item(OP_TICK, 10'd0, 8'd0, 8'd0);
    send_item(OP_TICK, 10'h3FF, 8'hFF, 8'hFF);
    send_item(OP_PACKET, 10'd512, MODE_TABLE, 8'd0);
    settle();
  endtask

  task automatic test_lever_buckets;
    logic [LEVER_W-1:0] levers[7];
    levers = '{10'd0, 10'd3, 10'd206, 10'd512, 10'd815, 10'd918, 10'd1023};
    write_reg(REG_LINK_TIMEOUT, 16'hFFFF);
    write_reg(REG_SEND_INTERVAL, 16'd1);
    write_reg(REG_NEUTRAL, 16'(NEUTRAL_RST));
    foreach (levers[i]) begin
      send_item(OP_PACKET, levers[i], MODE_TABLE, 8'd0);
      send_item(OP_TICK, 10'd0, 8'd0, 8'd0);
    end
    settle();
  endtask

  task automatic test_mode_and_stop;
    write_reg(REG_NEUTRAL, 16'h0555);
    send_item(OP_PACKET, 10'd700, 8'd0, 8'd0);
    send_item(OP_TICK, 10'd0, 8'd0, 8'd0);
    send_item(OP_PACKET, 10'd700, 8'hFF, STOP_ON);
    send_item(OP_TICK, 10'd0, 8'd0, 8'd0);
    send_item(OP_PACKET, 10'd1023, MODE_TABLE, 8'hFF);
    send_item(OP_TICK, 10'd0, 8'd0, 8'd0);
    send_item(OP_PACKET, 10'd1, MODE_TABLE, STOP_ON);
    send_item(OP_TICK, 10'd0, 8'd0, 8'd0);
    settle();
  endtask

  // Every tick sends a frame while the receiver holds off, so the result
  // path backs up into the input.
  task automatic test_output_stall;
    write_reg(REG_SEND_INTERVAL, 16'd1);
    hold_req = 1'b1;
    for (int i = 0; i < 18; i++) begin
      if (i % 6 == 5) send_item(OP_PACKET, 10'($urandom_range(1023)), MODE_TABLE, 8'd0);
      else send_item(OP_TICK, 10'd0, 8'd0, 8'd0);
    end
    settle();
  endtask

  task automatic test_random_phases;
    logic [15:0] timeout_v;
    logic [15:0] interval_v;
    logic [15:0] neutral_v;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          timeout_v  = 16'd0;
          interval_v = 16'd0;
          neutral_v  = 16'd0;
        end
        1: begin
          timeout_v  = 16'hFFFF;
          interval_v = 16'd1;
          neutral_v  = 16'hFFFF;
        end
        2: begin
          timeout_v  = 16'($urandom_range(8, 2));
          interval_v = 16'hFFFF;
          neutral_v  = 16'($urandom_range(16'hFFFF));
        end
        default: begin
          timeout_v  = ($urandom_range(3) == 0) ? 16'd1 : 16'($urandom_range(8, 2));
          interval_v = 16'($urandom_range(5, 1));
          neutral_v  = 16'($urandom_range(4095));
        end
      endcase
      write_reg(REG_LINK_TIMEOUT, timeout_v);
      write_reg(REG_SEND_INTERVAL, interval_v);
      write_reg(REG_NEUTRAL, neutral_v);
      if (phase == 2) write_reg(REG_UNUSED, 16'($urandom_range(16'hFFFF)));
      // One phase runs with both sides streaming without a gap.
      idle_on = (phase != 3);
      repeat (PHASE_ITEMS) send_random_item();
      settle();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    idle_on   = 1'b1;
    hold_req  = 1'b0;

    link_timeout  = LINK_TIMEOUT_RST;
    send_interval = SEND_INTERVAL_RST;
    neutral_tgt   = NEUTRAL_RST;
    held_tgt      = 12'd2048;
    now_ms        = '0;
    last_rx_ms    = '0;
    last_send_ms  = '0;
    stop_on       = 1'b0;
    link_up       = 1'b0;
    acks_sent     = '0;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_lever_buckets();
    test_mode_and_stop();
    test_output_stall();
    test_random_phases();
    settle();

    if (mismatch_count == 0) begin
      $display("** failsafe_actuator_command_link: PASSED **");
    end else begin
      $display("** failsafe_actuator_command_link: FAILED **");
    end
    $finish;
  end

endmodule
